// ----- rtl/core/imu_bcd_frame_parser_defines.svh -----
// Assertion macros shared by the frame parser modules.
`ifndef IMU_BCD_FRAME_PARSER_DEFINES_SVH
`define IMU_BCD_FRAME_PARSER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define IBFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define IBFP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/core/ibfp_pkg.sv -----
// Types, constants and decode helpers of the BCD frame parser.
package ibfp_pkg;

  localparam int FRAME_BYTES = 57;
  localparam int FIELD_COUNT = 16;
  localparam int ANGLE_FIELDS = 12;

  typedef logic [5:0] fill_t;
  localparam fill_t FILL_ARM  = 6'd56;
  localparam fill_t FILL_FULL = 6'd57;

  localparam logic [3:0] QTY_LAST = 4'd15;

  localparam logic [27:0] VALUE_MAX   = 28'd98099019;
  localparam logic [27:0] ACCEL_SCALE = 28'd981;
  localparam logic [27:0] QUAT_SCALE  = 28'd100;

  localparam logic [2:0] PLACES_ANGLE = 3'd2;
  localparam logic [2:0] PLACES_ACCEL = 3'd6;
  localparam logic [2:0] PLACES_MAGN  = 3'd5;
  localparam logic [2:0] PLACES_QUAT  = 3'd6;

  // Register index taken from paddr[2].
  localparam logic REG_HEADER = 1'b0;

  typedef enum logic [1:0] {
    GRP_PLAIN,
    GRP_ACCEL,
    GRP_MAGN,
    GRP_QUAT
  } qty_group_t;

  // Four bytes of one field, first byte on top; three-byte fields have a zero low byte.
  typedef logic [FIELD_COUNT-1:0][31:0] field_arr_t;

  typedef struct packed {
    logic hit;
    logic near_full;
  } win_status_t;

  // Low nibble of byte 0, then both nibbles of bytes 1 and 2, as decimal digits.
  function automatic logic [17:0] bcd5(input logic [23:0] b);
    logic [17:0] acc;
    acc = 18'(b[19:16]) * 18'd10000
        + 18'(b[15:12]) * 18'd1000
        + 18'(b[11:8])  * 18'd100
        + 18'(b[7:4])   * 18'd10
        + 18'(b[3:0]);
    return acc;
  endfunction

  function automatic qty_group_t qty_group(input logic [3:0] qty);
    qty_group_t g;
    if (qty >= 4'd12) begin
      g = GRP_QUAT;
    end else if (qty >= 4'd9) begin
      g = GRP_MAGN;
    end else if (qty >= 4'd3 && qty <= 4'd5) begin
      g = GRP_ACCEL;
    end else begin
      g = GRP_PLAIN;
    end
    return g;
  endfunction

  function automatic logic [2:0] places_of(input qty_group_t g);
    logic [2:0] p;
    unique case (g)
      GRP_PLAIN: p = PLACES_ANGLE;
      GRP_ACCEL: p = PLACES_ACCEL;
      GRP_MAGN:  p = PLACES_MAGN;
      GRP_QUAT:  p = PLACES_QUAT;
      default:   p = PLACES_ANGLE;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/ibfp_ifs.sv -----
// Valid/ready channel interfaces for received bytes and decoded results.
interface ibfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ibfp_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         quantity;
  logic signed [27:0] value;
  logic [2:0]         decimal_places;
  logic               last;

  modport source (output valid, output quantity, output value, output decimal_places,
                  output last, input ready);
  modport sink (input valid, input quantity, input value, input decimal_places,
                input last, output ready);
endinterface

// ----- rtl/core/imu_bcd_frame_parser.sv -----
// Top level of the inertial sensor BCD frame parser with its register port.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+---------------------------------------------
//   rx       | in  | valid / ready | rx_byte[7:0]
//   result   | out | valid / ready | quantity[3:0] value[27:0] decimal_places[2:0] last
//   apb      | in  | psel/penable  | paddr[2:0] pwdata[31:0] -> prdata[31:0]
//
// One received byte is taken every cycle while rx.ready is high. A byte that
// completes a good frame hands 16 fields to the decode sequencer, which issues
// one request per cycle while stage one can take it, through two registered
// stages ahead of the result channel.
// Reset (rst, synchronous) empties the window, zeroes the header register and
// drops all pending results. A stalled sink only holds off rx once the window
// holds 56 or more bytes while the previous frame's fields are still queued.
module imu_bcd_frame_parser #(
  parameter int HEADER_BYTES = 4
) (
  input  logic          clk,
  input  logic          rst,
  ibfp_byte_if.sink     rx,
  ibfp_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic                   rx_fire;
  logic [31:0]            header_word;
  logic                   dec_busy;
  ibfp_pkg::win_status_t  win_status;
  ibfp_pkg::field_arr_t   win_fields;

  // Register port: single header register at word 0; other words read zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ibfp_pkg::REG_HEADER) ? header_word : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_word <= '0;
    end else if (psel && penable && pwrite && paddr[2] == ibfp_pkg::REG_HEADER) begin
      header_word <= pwdata;
    end
  end

  // The window can complete a frame only from the arm point on, so bytes are
  // refused there only while the decoder still holds the previous frame.
  assign rx.ready = !dec_busy || !win_status.near_full;
  assign rx_fire  = rx.valid && rx.ready;

  ibfp_window #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .accept      (rx_fire),
    .rx_byte     (rx.rx_byte),
    .header_word (header_word),
    .status      (win_status),
    .fields      (win_fields)
  );

  // A detected frame loads straight into the decoder's field buffer.
  ibfp_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .load   (win_status.hit),
    .fields (win_fields),
    .busy   (dec_busy),
    .result (result)
  );

endmodule

// ----- rtl/core/ibfp_window.sv -----
// Byte window, running checksum, header match and frame detection.
`include "imu_bcd_frame_parser_defines.svh"

module ibfp_window #(
  parameter int HEADER_BYTES = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               rx_byte,
  input  logic [31:0]              header_word,
  output ibfp_pkg::win_status_t    status,
  output ibfp_pkg::field_arr_t     fields
);

  logic [7:0]      sreg [ibfp_pkg::FRAME_BYTES];
  logic [7:0]      sum;
  logic [7:0]      sum_next;
  ibfp_pkg::fill_t fill_count;
  ibfp_pkg::fill_t fill_next;
  logic            header_ok;
  logic            near_full;
  logic            hit;

  // Running sum of window bytes 1..55 after the shift this byte causes.
  always_comb begin
    sum_next = sum - sreg[1] + sreg[ibfp_pkg::FRAME_BYTES-1];
  end

  // The shifted window's header bytes sit one place up in the current one.
  always_comb begin
    header_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (i < HEADER_BYTES && sreg[i+1] != header_word[31-8*i -: 8]) begin
        header_ok = 1'b0;
      end
    end
  end

  assign near_full = (fill_count >= ibfp_pkg::FILL_ARM);
  assign hit       = accept && near_full && header_ok && (sum_next == rx_byte);

  always_comb begin
    priority if (!accept) begin
      fill_next = fill_count;
    end else if (hit) begin
      fill_next = '0;
    end else if (fill_count < ibfp_pkg::FILL_FULL) begin
      fill_next = fill_count + 6'd1;
    end else begin
      fill_next = fill_count;
    end
  end

  // Field bytes as they will stand in the window once this byte is in.
  always_comb begin
    for (int k = 0; k < ibfp_pkg::FIELD_COUNT; k++) begin
      if (k < ibfp_pkg::ANGLE_FIELDS) begin
        fields[k] = {sreg[4+3*k+1], sreg[4+3*k+2], sreg[4+3*k+3], 8'h00};
      end else begin
        fields[k] = {sreg[40+4*(k-12)+1], sreg[40+4*(k-12)+2],
                     sreg[40+4*(k-12)+3], sreg[40+4*(k-12)+4]};
      end
    end
  end

  assign status.hit       = hit;
  assign status.near_full = near_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      sum        <= '0;
      for (int i = 0; i < ibfp_pkg::FRAME_BYTES; i++) begin
        sreg[i] <= '0;
      end
    end else begin
      fill_count <= fill_next;
      if (accept) begin
        sum <= sum_next;
        for (int i = 0; i < ibfp_pkg::FRAME_BYTES - 1; i++) begin
          sreg[i] <= sreg[i+1];
        end
        sreg[ibfp_pkg::FRAME_BYTES-1] <= rx_byte;
      end
    end
  end

  `IBFP_ASSERT(a_hit_clears_fill, hit |=> fill_count == 6'd0, "window not emptied after a frame")
  `IBFP_ASSERT(a_fill_steps, accept && !near_full |=> fill_count == $past(fill_count) + 6'd1, "fill count did not advance")

endmodule

// ----- rtl/core/ibfp_decode.sv -----
// Field sequencer and two-stage BCD decode feeding the result channel.
`include "imu_bcd_frame_parser_defines.svh"

module ibfp_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ibfp_pkg::field_arr_t fields,
  output logic                 busy,
  ibfp_result_if.source        result
);

  // Sequencer: field buffer shifted down by one field per issued result.
  logic        seq_active;
  logic [3:0]  k;
  logic [31:0] fld [ibfp_pkg::FIELD_COUNT];
  logic        seq_fire;

  // Stage one: digit sums.
  logic        s1_valid;
  logic [3:0]  s1_qty;
  logic        s1_neg;
  logic [17:0] s1_digits;
  logic [7:0]  s1_tail;
  logic        s1_ready;
  logic        s1_take;

  // Stage two: scale, clamp and sign.
  logic                   s2_ready;
  ibfp_pkg::qty_group_t   grp;
  logic [27:0]            mag_wide;
  logic [27:0]            mag_sat;
  logic signed [27:0]     value_next;
  logic [7:0]             tail_next;

  assign s2_ready = !result.valid || result.ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s1_take  = s1_valid && s2_ready;
  assign seq_fire = seq_active && s1_ready;
  assign busy     = seq_active;

  // Two trailing quaternion digits: high nibble tens, low nibble units.
  assign tail_next = 8'(fld[0][7:4]) * 8'd10 + 8'(fld[0][3:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
      k          <= '0;
    end else if (load) begin
      seq_active <= 1'b1;
      k          <= '0;
    end else if (seq_fire) begin
      k <= k + 4'd1;
      if (k == ibfp_pkg::QTY_LAST) begin
        seq_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < ibfp_pkg::FIELD_COUNT; i++) begin
        fld[i] <= fields[i];
      end
    end else if (seq_fire) begin
      for (int i = 0; i < ibfp_pkg::FIELD_COUNT - 1; i++) begin
        fld[i] <= fld[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (seq_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_fire) begin
      s1_qty    <= k;
      s1_neg    <= (fld[0][31:28] != 4'd0);
      s1_digits <= ibfp_pkg::bcd5(fld[0][31:8]);
      s1_tail   <= tail_next;
    end
  end

  always_comb begin
    grp = ibfp_pkg::qty_group(s1_qty);
    unique case (grp)
      ibfp_pkg::GRP_ACCEL: mag_wide = 28'(s1_digits) * ibfp_pkg::ACCEL_SCALE;
      ibfp_pkg::GRP_QUAT:  mag_wide = 28'(s1_digits) * ibfp_pkg::QUAT_SCALE + 28'(s1_tail);
      default:             mag_wide = 28'(s1_digits);
    endcase
    mag_sat    = (mag_wide > ibfp_pkg::VALUE_MAX) ? ibfp_pkg::VALUE_MAX : mag_wide;
    value_next = s1_neg ? -$signed(mag_sat) : $signed(mag_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      result.quantity       <= s1_qty;
      result.value          <= value_next;
      result.decimal_places <= ibfp_pkg::places_of(grp);
      result.last           <= (s1_qty == ibfp_pkg::QTY_LAST);
    end
  end

  `IBFP_ASSERT_NEVER(a_load_while_busy, load && seq_active, "frame loaded while fields still pending")
  `IBFP_ASSERT(a_seq_ends, seq_fire && k == ibfp_pkg::QTY_LAST |=> !seq_active, "sequencer ran past the last field")
  `IBFP_ASSERT(a_last_is_quat, result.valid && result.last |-> result.quantity == ibfp_pkg::QTY_LAST, "last flag on a wrong field")

endmodule
